FILE: hdl/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg: piston position controller shared definitions
// Types, codes and drive helpers used by the controller core, the register
// bank and the top level.
// ----------------------------------------------------------------------------
package ppc_pkg;

   // Event codes carried in the func field of an input item
   localparam logic [2:0] FUNC_LOOP      = 3'd0;
   localparam logic [2:0] FUNC_MS_TICK   = 3'd1;
   localparam logic [2:0] FUNC_SEC_TICK  = 3'd2;
   localparam logic [2:0] FUNC_SET_TGT   = 3'd3;
   localparam logic [2:0] FUNC_RESET     = 3'd4;
   localparam logic [2:0] FUNC_EMERGENCY = 3'd5;

   // Configuration register indexes
   localparam logic [2:0] CSR_SPEED_LIMIT   = 3'd0;
   localparam logic [2:0] CSR_RESET_SPEED   = 3'd1;
   localparam logic [2:0] CSR_RAMP_STEP     = 3'd2;
   localparam logic [2:0] CSR_DEADBAND      = 3'd3;
   localparam logic [2:0] CSR_TORQUE_HOLD   = 3'd4;
   localparam logic [2:0] CSR_DRIVE_ENABLE  = 3'd5;
   localparam logic [2:0] CSR_WATCHDOG_SEC  = 3'd6;
   localparam logic [2:0] CSR_RESET_SEC     = 3'd7;

   // Reported mode codes
   localparam logic [1:0] MODE_CODE_RESET_OUT = 2'd0;
   localparam logic [1:0] MODE_CODE_REGULATE  = 2'd1;
   localparam logic [1:0] MODE_CODE_EMERGENCY = 2'd2;

   // Fixed plant constants
   localparam logic signed [15:0] INNER_LIMIT = 16'sd5660;
   localparam logic [8:0]         DUTY_MID    = 9'd200;
   localparam logic [8:0]         DUTY_MAX    = 9'd400;
   localparam logic [7:0]         SPEED_MAX   = 8'd200;
   localparam logic [7:0]         HOLD_SAT    = 8'd255;

   // Register reset values
   localparam logic [7:0] SPEED_LIMIT_RST  = 8'd150;
   localparam logic [7:0] RESET_SPEED_RST  = 8'd200;
   localparam logic [7:0] RAMP_STEP_RST    = 8'd2;
   localparam logic [7:0] DEADBAND_RST     = 8'd0;
   localparam logic [7:0] TORQUE_HOLD_RST  = 8'd10;
   localparam logic [7:0] WATCHDOG_SEC_RST = 8'd60;
   localparam logic [7:0] RESET_SEC_RST    = 8'd30;

   typedef enum logic [2:0] {
      MODE_RESET_OUT = 3'b001,
      MODE_REGULATE  = 3'b010,
      MODE_EMERGENCY = 3'b100
   } ppc_mode_type;

   typedef struct packed {
      logic [7:0] speed_limit;
      logic [7:0] reset_speed;
      logic [7:0] ramp_step;
      logic [7:0] deadband;
      logic [7:0] torque_hold_ticks;
      logic       drive_enable;
      logic [7:0] watchdog_seconds;
      logic [7:0] reset_seconds;
   } ppc_cfg_type;

   typedef struct packed {
      logic [2:0]  func;
      logic        sensor_a;
      logic        sensor_b;
      logic [15:0] target_raw;
   } ppc_item_type;

   typedef struct packed {
      logic [8:0]         drive_duty;
      logic               torque_on;
      logic signed [15:0] position_count;
      logic [1:0]         mode;
      logic               at_out_stop;
      logic               at_in_stop;
      logic signed [15:0] position_error;
   } ppc_result_type;

   typedef struct packed {
      logic [8:0] duty;
      logic       torque;
      logic [7:0] hold;
   } ppc_drive_type;

   // Map the one-hot mode to its reported code
   function automatic logic [1:0] ppc_mode_code(input ppc_mode_type mode);
      logic [1:0] code;
      unique case (mode)
         MODE_REGULATE:  code = MODE_CODE_REGULATE;
         MODE_EMERGENCY: code = MODE_CODE_EMERGENCY;
         default:        code = MODE_CODE_RESET_OUT;
      endcase
      return code;
   endfunction

   // Quadrature step: +1, -1 or no count as a 16-bit increment
   function automatic logic [15:0] ppc_quad_step(input logic [1:0] last,
                                                 input logic [1:0] now);
      logic [15:0] inc;
      inc = 16'd0;
      unique case (last)
         2'd0: if (now == 2'd1) inc = 16'hFFFF; else if (now == 2'd2) inc = 16'd1;
         2'd1: if (now == 2'd3) inc = 16'hFFFF; else if (now == 2'd0) inc = 16'd1;
         2'd2: if (now == 2'd0) inc = 16'hFFFF; else if (now == 2'd3) inc = 16'd1;
         default: if (now == 2'd1) inc = 16'd1; else if (now == 2'd2) inc = 16'hFFFF;
      endcase
      return inc;
   endfunction

   // Stop update: snap to midpoint, release torque after the hold delay
   function automatic ppc_drive_type ppc_stop(input ppc_drive_type cur,
                                              input logic [7:0] hold_ticks);
      ppc_drive_type nxt;
      nxt = cur;
      if (cur.duty != DUTY_MID) begin
         nxt.duty   = DUTY_MID;
         nxt.torque = 1'b1;
      end
      if (cur.hold > hold_ticks) begin
         nxt.torque = 1'b0;
      end else if (cur.hold != HOLD_SAT) begin
         nxt.hold = cur.hold + 8'd1;
      end
      return nxt;
   endfunction

   // Drive update: stop at end stops or with the drive disabled, otherwise slew toward the wanted duty
   function automatic ppc_drive_type ppc_cmd(input ppc_drive_type cur,
                                             input logic [8:0] want,
                                             input ppc_cfg_type cfg,
                                             input logic out_stop,
                                             input logic in_stop);
      ppc_drive_type     nxt;
      logic signed [10:0] diff;
      logic signed [10:0] step;
      logic [10:0]        sum;
      nxt  = cur;
      diff = $signed({2'b00, want}) - $signed({2'b00, cur.duty});
      step = $signed({3'b000, cfg.ramp_step});
      if (!cfg.drive_enable || (out_stop && want >= DUTY_MID) ||
          (in_stop && want <= DUTY_MID)) begin
         nxt = ppc_stop(cur, cfg.torque_hold_ticks);
      end else if (cur.duty != want) begin
         if (diff > step) begin
            diff = step;
         end else if (diff < -step) begin
            diff = -step;
         end
         sum        = {2'b00, cur.duty} + $unsigned(diff);
         nxt.duty   = sum[8:0];
         nxt.torque = 1'b1;
         nxt.hold   = 8'd0;
      end
      return nxt;
   endfunction

endpackage

FILE: hdl/ppc_channels.sv
// ----------------------------------------------------------------------------
// ppc_channels: request and response channel interfaces
// Valid/ready channels carrying controller events in and status items out.
// ----------------------------------------------------------------------------
interface ppc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic        sensor_a;
   logic        sensor_b;
   logic [15:0] target_raw;

   modport source (output valid, func, sensor_a, sensor_b, target_raw, input ready);
   modport sink (input valid, func, sensor_a, sensor_b, target_raw, output ready);
endinterface

interface ppc_rsp_if;
   logic               valid;
   logic               ready;
   logic [8:0]         drive_duty;
   logic               torque_on;
   logic signed [15:0] position_count;
   logic [1:0]         mode;
   logic               at_out_stop;
   logic               at_in_stop;
   logic signed [15:0] position_error;

   modport source (output valid, drive_duty, torque_on, position_count, mode,
                   at_out_stop, at_in_stop, position_error, input ready);
   modport sink (input valid, drive_duty, torque_on, position_count, mode,
                 at_out_stop, at_in_stop, position_error, output ready);
endinterface

FILE: hdl/ppc_csr.sv
// ----------------------------------------------------------------------------
// ppc_csr: configuration register bank
// Write-only tuning registers; speed offsets above the allowed maximum are
// dropped.
// ----------------------------------------------------------------------------
module ppc_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [7:0]         csr_wdata,
   output ppc_pkg::ppc_cfg_type cfg
);
   import ppc_pkg::*;

   ppc_cfg_type cfg_ff;
   ppc_cfg_type cfg_in;

   // Decode one write into the register image
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SPEED_LIMIT: if (csr_wdata <= SPEED_MAX) cfg_in.speed_limit = csr_wdata;
            CSR_RESET_SPEED: if (csr_wdata <= SPEED_MAX) cfg_in.reset_speed = csr_wdata;
            CSR_RAMP_STEP:    cfg_in.ramp_step         = csr_wdata;
            CSR_DEADBAND:     cfg_in.deadband          = csr_wdata;
            CSR_TORQUE_HOLD:  cfg_in.torque_hold_ticks = csr_wdata;
            CSR_DRIVE_ENABLE: cfg_in.drive_enable      = csr_wdata[0];
            CSR_WATCHDOG_SEC: cfg_in.watchdog_seconds  = csr_wdata;
            CSR_RESET_SEC:    cfg_in.reset_seconds     = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_limit       <= SPEED_LIMIT_RST;
         cfg_ff.reset_speed       <= RESET_SPEED_RST;
         cfg_ff.ramp_step         <= RAMP_STEP_RST;
         cfg_ff.deadband          <= DEADBAND_RST;
         cfg_ff.torque_hold_ticks <= TORQUE_HOLD_RST;
         cfg_ff.drive_enable      <= 1'b1;
         cfg_ff.watchdog_seconds  <= WATCHDOG_SEC_RST;
         cfg_ff.reset_seconds     <= RESET_SEC_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/ppc_engine.sv
// ----------------------------------------------------------------------------
// ppc_engine: controller state and event processing
// Holds the mode machine, position count, target, drive and timers, and
// applies one event per advance. The result reflects the state after it.
// ----------------------------------------------------------------------------
module ppc_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  ppc_pkg::ppc_item_type  item,
   input  ppc_pkg::ppc_cfg_type   cfg,
   output ppc_pkg::ppc_result_type result
);
   import ppc_pkg::*;

   ppc_mode_type  mode_ff,       mode_in;
   logic [15:0]   pulse_ff,      pulse_in;
   logic [1:0]    last_sensor_ff, last_sensor_in;
   logic [15:0]   target_ff,     target_in;
   ppc_drive_type drive_ff,      drive_in;
   logic          tick_ff,       tick_in;
   logic [7:0]    wd_ff,         wd_in;
   logic [7:0]    rst_cnt_ff,    rst_cnt_in;
   logic          out_stop_ff,   out_stop_in;
   logic          in_stop_ff,    in_stop_in;
   logic [15:0]   error_ff,      error_in;

   logic [1:0]         now;
   logic [15:0]        pulse_dec;
   logic [15:0]        err;
   logic signed [16:0] err_s;
   logic signed [16:0] db_s;

   assign now       = {item.sensor_b, item.sensor_a};
   assign pulse_dec = pulse_ff + ppc_quad_step(last_sensor_ff, now);
   assign err       = target_ff - pulse_dec;
   assign err_s     = $signed({err[15], err});
   assign db_s      = $signed({9'd0, cfg.deadband});

   // Apply one event
   always_comb begin
      mode_in        = mode_ff;
      pulse_in       = pulse_ff;
      last_sensor_in = last_sensor_ff;
      target_in      = target_ff;
      drive_in       = drive_ff;
      tick_in        = tick_ff;
      wd_in          = wd_ff;
      rst_cnt_in     = rst_cnt_ff;
      out_stop_in    = out_stop_ff;
      in_stop_in     = in_stop_ff;
      error_in       = error_ff;
      if (advance) begin
         unique case (item.func)
            FUNC_LOOP: begin
               // end-stop flags come from the count before this pass
               out_stop_in = ($signed(pulse_ff) <= 16'sd0);
               in_stop_in  = ($signed(pulse_ff) >= INNER_LIMIT);
               unique case (mode_ff)
                  MODE_RESET_OUT: begin
                     if (rst_cnt_ff == 8'd0) begin
                        mode_in        = MODE_REGULATE;
                        last_sensor_in = now;
                        pulse_in       = 16'd0;
                        target_in      = 16'd0;
                        drive_in       = ppc_stop(drive_ff, cfg.torque_hold_ticks);
                     end else begin
                        drive_in = ppc_cmd(drive_ff, DUTY_MID + {1'b0, cfg.reset_speed},
                                           cfg, out_stop_in, in_stop_in);
                     end
                  end
                  MODE_REGULATE: begin
                     pulse_in       = pulse_dec;
                     last_sensor_in = now;
                     if (tick_ff) begin
                        error_in = err;
                        tick_in  = 1'b0;
                        if (err_s > db_s) begin
                           drive_in = ppc_cmd(drive_ff, DUTY_MID - {1'b0, cfg.speed_limit},
                                              cfg, out_stop_in, in_stop_in);
                        end else if (err_s < -db_s) begin
                           drive_in = ppc_cmd(drive_ff, DUTY_MID + {1'b0, cfg.speed_limit},
                                              cfg, out_stop_in, in_stop_in);
                        end else begin
                           drive_in = ppc_stop(drive_ff, cfg.torque_hold_ticks);
                        end
                     end
                  end
                  MODE_EMERGENCY: begin
                     drive_in = ppc_cmd(drive_ff, DUTY_MID + {1'b0, cfg.reset_speed},
                                        cfg, out_stop_in, in_stop_in);
                  end
                  default: begin
                     drive_in = drive_ff;
                  end
               endcase
            end
            FUNC_MS_TICK: begin
               tick_in = 1'b1;
            end
            FUNC_SEC_TICK: begin
               // watchdog expiry drops the target
               if (wd_ff != 8'd0) begin
                  wd_in = wd_ff - 8'd1;
               end else begin
                  target_in = 16'd0;
                  wd_in     = cfg.watchdog_seconds;
               end
               if (mode_ff == MODE_RESET_OUT && rst_cnt_ff != 8'd0) begin
                  rst_cnt_in = rst_cnt_ff - 8'd1;
               end
            end
            FUNC_SET_TGT: begin
               target_in = {item.target_raw[13:0], 2'b00};
               wd_in     = cfg.watchdog_seconds;
            end
            FUNC_RESET: begin
               mode_in    = MODE_RESET_OUT;
               rst_cnt_in = cfg.reset_seconds;
               wd_in      = cfg.watchdog_seconds;
            end
            FUNC_EMERGENCY: begin
               mode_in = MODE_EMERGENCY;
               wd_in   = cfg.watchdog_seconds;
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   // Hold the controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_RESET_OUT;
         pulse_ff        <= 16'd0;
         last_sensor_ff  <= 2'd0;
         target_ff       <= 16'd0;
         drive_ff.duty   <= DUTY_MID;
         drive_ff.torque <= 1'b0;
         drive_ff.hold   <= 8'd0;
         tick_ff         <= 1'b0;
         wd_ff           <= WATCHDOG_SEC_RST;
         rst_cnt_ff      <= RESET_SEC_RST;
         out_stop_ff     <= 1'b0;
         in_stop_ff      <= 1'b0;
         error_ff        <= 16'd0;
      end else begin
         mode_ff        <= mode_in;
         pulse_ff       <= pulse_in;
         last_sensor_ff <= last_sensor_in;
         target_ff      <= target_in;
         drive_ff       <= drive_in;
         tick_ff        <= tick_in;
         wd_ff          <= wd_in;
         rst_cnt_ff     <= rst_cnt_in;
         out_stop_ff    <= out_stop_in;
         in_stop_ff     <= in_stop_in;
         error_ff       <= error_in;
      end
   end

   // Report the state after the event
   assign result.drive_duty     = drive_in.duty;
   assign result.torque_on      = drive_in.torque;
   assign result.position_count = $signed(pulse_in);
   assign result.mode           = ppc_mode_code(mode_in);
   assign result.at_out_stop    = out_stop_in;
   assign result.at_in_stop     = in_stop_in;
   assign result.position_error = $signed(error_in);

   // Duty stays within the commanded range
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      drive_ff.duty <= DUTY_MAX)
      else $error("drive duty out of range");

   // Torque is only released with the drive at midpoint
   a_release_mid: assert property (@(posedge clock) disable iff (reset)
      $fell(drive_ff.torque) |-> drive_ff.duty == DUTY_MID)
      else $error("torque released away from midpoint");

   // A pending tick is consumed only by a regulation pass
   a_tick_consume: assert property (@(posedge clock) disable iff (reset)
      $fell(tick_ff) |-> $past(mode_ff) == MODE_REGULATE && $past(advance))
      else $error("tick cleared outside regulation");

   // State holds between items
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(pulse_ff) && $stable(target_ff) && $stable(drive_ff)
                   && $stable(mode_ff))
      else $error("state changed without an item");

endmodule

FILE: hdl/piston_position_controller_unit.sv
// ----------------------------------------------------------------------------
// piston_position_controller_unit: piston drive position controller
// Quadrature count, mode machine and slew-limited bang-bang drive, one
// status item returned for every event item.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake         Carries
//  req_ch   in   valid/ready       func, sensor_a, sensor_b, target_raw
//  rsp_ch   out  valid/ready       duty, torque, count, mode, stop flags, error
//  csr_*    in   csr_we strobe     register index and 8-bit data
//
//  One item per cycle sustained while the result channel takes results; an
//  item is registered on accept and its result is registered when it advances.
//  The event logic sits between the item register and the result register.
//  Reset is synchronous and clears the valid flags and all controller state at once; no clearing pass.
//  A stalled result holds; one further item is taken into the item register,
//  then req_ch.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module piston_position_controller_unit (
   input  logic       clock,
   input  logic       reset,
   ppc_req_if.sink    req_ch,
   ppc_rsp_if.source  rsp_ch,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import ppc_pkg::*;

   ppc_cfg_type    cfg;
   ppc_item_type   item_ff;
   ppc_result_type result;
   ppc_result_type rsp_ff;
   logic           item_valid_ff, item_valid_in;
   logic           rsp_valid_ff,  rsp_valid_in;
   logic           advance;
   logic           req_take;

   ppc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ppc_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // Advance when an item is held and the result slot is free or draining
   assign advance      = item_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !item_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_take) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Capture the incoming item and the finished result
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.func       <= req_ch.func;
         item_ff.sensor_a   <= req_ch.sensor_a;
         item_ff.sensor_b   <= req_ch.sensor_b;
         item_ff.target_raw <= req_ch.target_raw;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.drive_duty     = rsp_ff.drive_duty;
   assign rsp_ch.torque_on      = rsp_ff.torque_on;
   assign rsp_ch.position_count = rsp_ff.position_count;
   assign rsp_ch.mode           = rsp_ff.mode;
   assign rsp_ch.at_out_stop    = rsp_ff.at_out_stop;
   assign rsp_ch.at_in_stop     = rsp_ff.at_in_stop;
   assign rsp_ch.position_error = rsp_ff.position_error;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: piston position controller testbench
// Drives event items into the controller through its valid/ready request
// channel and checks every status item against a cycle-free model of the
// quadrature count, the mode machine and the slew-limited drive. Register
// settings change between phases; both channels idle and stall in bursts.
// ----------------------------------------------------------------------------
module tb;
   import ppc_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int REPORT_CAP  = 40;
   localparam int PHASE_ITEMS = 56;
   localparam int WALK_STEPS  = 64;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       csr_we    = 1'b0;
   logic [2:0] csr_index = CSR_SPEED_LIMIT;
   logic [7:0] csr_wdata = 8'd0;

   ppc_req_if req_if ();
   ppc_rsp_if rsp_if ();

   piston_position_controller_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Model state of the controller and its register copy
   ppc_cfg_type ctl_cfg;
   logic [1:0]  ctl_mode;
   logic [15:0] ctl_count;
   logic [15:0] ctl_target;
   logic [15:0] ctl_error;
   logic [1:0]  ctl_sensor;
   logic [8:0]  ctl_duty;
   logic        ctl_torque;
   logic        ctl_tick;
   logic        ctl_out_stop;
   logic        ctl_in_stop;
   logic [7:0]  ctl_hold;
   logic [7:0]  ctl_wdog;
   logic [7:0]  ctl_secs;

   // Items waiting to be sent and status items waiting to arrive
   ppc_item_type   event_backlog[$];
   ppc_result_type expected_status_q[$];

   // Handshake bookkeeping between the driver and the monitor
   logic req_took    = 1'b0;
   logic in_hand     = 1'b0;
   logic src_gaps_on = 1'b0;
   logic snk_gaps_on = 1'b0;
   int   src_gap     = 0;
   int   snk_gap     = 0;
   int   quiet_cycles = 0;

   // Run statistics
   int fail_count      = 0;
   int items_taken     = 0;
   int results_checked = 0;
   int csr_writes      = 0;
   int regulate_seen   = 0;
   int in_stop_seen    = 0;

   // Stimulus generator state
   logic [1:0] gen_ab  = 2'd0;
   logic       gen_fwd = 1'b1;
   int         gen_pos = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   // Next quadrature state in the counting or the opposite direction
   function automatic logic [1:0] quad_next(input logic [1:0] s, input logic forward);
      logic [1:0] nxt;
      case (s)
         2'd0:    nxt = forward ? 2'd2 : 2'd1;
         2'd1:    nxt = forward ? 2'd0 : 2'd3;
         2'd2:    nxt = forward ? 2'd3 : 2'd0;
         default: nxt = forward ? 2'd1 : 2'd2;
      endcase
      return nxt;
   endfunction

   // Count change for one sensor reading; repeats and two-state jumps count zero
   function automatic int quad_delta(input logic [1:0] was, input logic [1:0] now);
      int d;
      d = 0;
      if (now == quad_next(was, 1'b1)) d = 1;
      else if (now == quad_next(was, 1'b0)) d = -1;
      return d;
   endfunction

   // Stop update: snap duty to midpoint, release torque once the hold expires
   function automatic void hold_stop();
      if (ctl_duty != DUTY_MID) begin
         ctl_duty   = DUTY_MID;
         ctl_torque = 1'b1;
      end
      if (ctl_hold > ctl_cfg.torque_hold_ticks) ctl_torque = 1'b0;
      else if (ctl_hold != HOLD_SAT) ctl_hold = ctl_hold + 8'd1;
   endfunction

   // Drive update: block motion into an active end stop or with the drive disabled, else slew toward want
   function automatic void slew_toward(input int want);
      int cur;
      int delta;
      int step;
      cur  = int'(ctl_duty);
      step = int'(ctl_cfg.ramp_step);
      if (want < 0) want = 0;
      if (want > 511) want = 511;
      if (!ctl_cfg.drive_enable || (ctl_out_stop && want >= int'(DUTY_MID)) ||
          (ctl_in_stop && want <= int'(DUTY_MID))) begin
         hold_stop();
      end else if (cur != want) begin
         delta = want - cur;
         if (delta > step) delta = step;
         else if (delta < -step) delta = -step;
         ctl_duty   = 9'(cur + delta);
         ctl_torque = 1'b1;
         ctl_hold   = 8'd0;
      end
   endfunction

   // Bang-bang position rule with deadband; consumes the pending tick
   function automatic void regulate_position();
      logic signed [15:0] diff;
      int err;
      int band;
      diff      = $signed(ctl_target - ctl_count);
      err       = diff;
      band      = int'(ctl_cfg.deadband);
      ctl_error = diff;
      if (err > band) slew_toward(int'(DUTY_MID) - int'(ctl_cfg.speed_limit));
      else if (err < -band) slew_toward(int'(DUTY_MID) + int'(ctl_cfg.speed_limit));
      else hold_stop();
      ctl_tick = 1'b0;
   endfunction

   // Loop pass: end-stop flags from the old count, then the mode machine
   function automatic void loop_pass(input logic [1:0] now);
      logic signed [15:0] pos;
      pos          = $signed(ctl_count);
      ctl_out_stop = (pos <= 0);
      ctl_in_stop  = (pos >= INNER_LIMIT);
      case (ctl_mode)
         MODE_CODE_RESET_OUT: begin
            if (ctl_secs == 8'd0) begin
               ctl_mode   = MODE_CODE_REGULATE;
               ctl_sensor = now;
               ctl_count  = 16'd0;
               ctl_target = 16'd0;
               hold_stop();
            end else begin
               slew_toward(int'(DUTY_MID) + int'(ctl_cfg.reset_speed));
            end
         end
         MODE_CODE_REGULATE: begin
            ctl_count  = ctl_count + 16'(quad_delta(ctl_sensor, now));
            ctl_sensor = now;
            if (ctl_tick) regulate_position();
         end
         MODE_CODE_EMERGENCY: begin
            slew_toward(int'(DUTY_MID) + int'(ctl_cfg.reset_speed));
         end
         default: ;
      endcase
   endfunction

   // Apply one event item to the model and return the status it reports
   function automatic ppc_result_type advance_controller(input ppc_item_type it);
      ppc_result_type res;
      case (it.func)
         FUNC_LOOP: loop_pass({it.sensor_b, it.sensor_a});
         FUNC_MS_TICK: ctl_tick = 1'b1;
         FUNC_SEC_TICK: begin
            if (ctl_wdog != 8'd0) begin
               ctl_wdog = ctl_wdog - 8'd1;
            end else begin
               ctl_target = 16'd0;
               ctl_wdog   = ctl_cfg.watchdog_seconds;
            end
            if (ctl_mode == MODE_CODE_RESET_OUT && ctl_secs != 8'd0) ctl_secs = ctl_secs - 8'd1;
         end
         FUNC_SET_TGT: begin
            ctl_target = {it.target_raw[13:0], 2'b00};
            ctl_wdog   = ctl_cfg.watchdog_seconds;
         end
         FUNC_RESET: begin
            ctl_mode = MODE_CODE_RESET_OUT;
            ctl_secs = ctl_cfg.reset_seconds;
            ctl_wdog = ctl_cfg.watchdog_seconds;
         end
         FUNC_EMERGENCY: begin
            ctl_mode = MODE_CODE_EMERGENCY;
            ctl_wdog = ctl_cfg.watchdog_seconds;
         end
         default: ;
      endcase
      res.drive_duty     = ctl_duty;
      res.torque_on      = ctl_torque;
      res.position_count = ctl_count;
      res.mode           = ctl_mode;
      res.at_out_stop    = ctl_out_stop;
      res.at_in_stop     = ctl_in_stop;
      res.position_error = ctl_error;
      return res;
   endfunction

   // Register write into the model; speed offsets above the maximum are dropped
   function automatic void note_csr_write(input logic [2:0] idx, input logic [7:0] data);
      case (idx)
         CSR_SPEED_LIMIT:  if (data <= SPEED_MAX) ctl_cfg.speed_limit = data;
         CSR_RESET_SPEED:  if (data <= SPEED_MAX) ctl_cfg.reset_speed = data;
         CSR_RAMP_STEP:    ctl_cfg.ramp_step = data;
         CSR_DEADBAND:     ctl_cfg.deadband = data;
         CSR_TORQUE_HOLD:  ctl_cfg.torque_hold_ticks = data;
         CSR_DRIVE_ENABLE: ctl_cfg.drive_enable = data[0];
         CSR_WATCHDOG_SEC: ctl_cfg.watchdog_seconds = data;
         default:          ctl_cfg.reset_seconds = data;
      endcase
   endfunction

   task automatic compare_field(input string name, input logic signed [16:0] want,
                                input logic signed [16:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= REPORT_CAP)
            $display("%0t tb: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         else if (fail_count == REPORT_CAP + 1)
            $display("%0t tb: further mismatches are counted but not shown", $time);
      end
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [7:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      note_csr_write(idx, data);
      csr_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_settings(input int speed, input int rspeed, input int ramp,
                                 input int band, input int hold, input int enable,
                                 input int wdog, input int secs);
      csr_write(CSR_SPEED_LIMIT, 8'(speed));
      csr_write(CSR_RESET_SPEED, 8'(rspeed));
      csr_write(CSR_RAMP_STEP, 8'(ramp));
      csr_write(CSR_DEADBAND, 8'(band));
      csr_write(CSR_TORQUE_HOLD, 8'(hold));
      csr_write(CSR_DRIVE_ENABLE, 8'(enable));
      csr_write(CSR_WATCHDOG_SEC, 8'(wdog));
      csr_write(CSR_RESET_SEC, 8'(secs));
   endtask

   // Wait until every item is sent and answered, then let the pipeline settle
   task automatic wait_idle();
      while (event_backlog.size() != 0 || in_hand || expected_status_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic push_event(input logic [2:0] f, input logic [1:0] ab,
                             input logic [15:0] raw);
      ppc_item_type it;
      it.func       = f;
      it.sensor_b   = ab[1];
      it.sensor_a   = ab[0];
      it.target_raw = raw;
      event_backlog.push_back(it);
   endtask

   // Reset command, count the reset-out time down, then a loop pass to regulate
   task automatic push_rehome();
      int ticks;
      ticks = (ctl_cfg.reset_seconds > 8'd12) ? 12 : int'(ctl_cfg.reset_seconds);
      push_event(FUNC_RESET, 2'($urandom), 16'($urandom));
      repeat (ticks) push_event(FUNC_SEC_TICK, 2'($urandom), 16'($urandom));
      push_event(FUNC_LOOP, gen_ab, 16'($urandom));
      gen_pos = 0;
   endtask

   // One random sequence: mostly encoder walks with ms ticks, some commands
   task automatic push_random_sequence();
      int pick;
      int n;
      int choice;
      logic [15:0] raw;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         n = $urandom_range(3, 20);
         if ($urandom_range(0, 3) == 0) gen_fwd = !gen_fwd;
         repeat (n) begin
            choice = $urandom_range(0, 19);
            if (choice == 0) begin
               gen_ab = gen_ab ^ 2'b11;
            end else if (choice != 1) begin
               gen_ab  = quad_next(gen_ab, gen_fwd);
               gen_pos = gen_pos + (gen_fwd ? 1 : -1);
            end
            push_event(FUNC_LOOP, gen_ab, 16'($urandom));
            if ($urandom_range(0, 2) == 0) push_event(FUNC_MS_TICK, 2'($urandom), 16'($urandom));
         end
      end else if (pick < 65) begin
         if ($urandom_range(0, 9) == 0) raw = 16'($urandom);
         else raw = 16'((gen_pos >>> 2) + int'($urandom_range(0, 30)) - 15);
         push_event(FUNC_SET_TGT, 2'($urandom), raw);
      end else if (pick < 75) begin
         push_event(FUNC_SEC_TICK, 2'($urandom), 16'($urandom));
      end else if (pick < 82) begin
         push_rehome();
      end else if (pick < 86) begin
         push_event(FUNC_EMERGENCY, 2'($urandom), 16'($urandom));
         repeat ($urandom_range(2, 8)) push_event(FUNC_LOOP, 2'($urandom), 16'($urandom));
         push_rehome();
      end else begin
         push_event(3'($urandom_range(0, 7)), 2'($urandom), 16'($urandom));
      end
   endtask

   // Driver: present items and result-channel ready, changing at the falling edge
   always @(negedge clock) begin : drive_channels
      ppc_item_type it;
      if (reset) begin
         req_if.valid <= 1'b0;
         rsp_if.ready <= 1'b0;
      end else begin
         // hold an item until taken; gaps fall only between items
         if (!req_if.valid || req_took) begin
            if (src_gap != 0) begin
               src_gap--;
               req_if.valid <= 1'b0;
            end else if (src_gaps_on && $urandom_range(0, 7) == 0) begin
               src_gap = $urandom_range(0, 12);
               req_if.valid <= 1'b0;
            end else if (event_backlog.size() != 0) begin
               it = event_backlog.pop_front();
               in_hand = 1'b1;
               req_if.valid      <= 1'b1;
               req_if.func       <= it.func;
               req_if.sensor_a   <= it.sensor_a;
               req_if.sensor_b   <= it.sensor_b;
               req_if.target_raw <= it.target_raw;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
         // stall the result channel in bursts
         if (snk_gap != 0) begin
            snk_gap--;
            rsp_if.ready <= 1'b0;
         end else if (snk_gaps_on && $urandom_range(0, 7) == 0) begin
            snk_gap = $urandom_range(0, 12);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Monitor: predict on each accepted item, check each accepted result
   always @(posedge clock) begin : watch_channels
      ppc_item_type   taken;
      ppc_result_type want;
      logic           moved;
      moved    = 1'b0;
      req_took = 1'b0;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            taken.func       = req_if.func;
            taken.sensor_a   = req_if.sensor_a;
            taken.sensor_b   = req_if.sensor_b;
            taken.target_raw = req_if.target_raw;
            expected_status_q.push_back(advance_controller(taken));
            req_took = 1'b1;
            in_hand  = 1'b0;
            moved    = 1'b1;
            items_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            moved = 1'b1;
            if (expected_status_q.size() == 0) begin
               fail_count++;
               $display("%0t tb: status item with none expected, actual duty %0d count %0d",
                        $time, rsp_if.drive_duty, rsp_if.position_count);
            end else begin
               want = expected_status_q.pop_front();
               compare_field("drive_duty", want.drive_duty, rsp_if.drive_duty);
               compare_field("torque_on", want.torque_on, rsp_if.torque_on);
               compare_field("position_count", want.position_count, rsp_if.position_count);
               compare_field("mode", want.mode, rsp_if.mode);
               compare_field("at_out_stop", want.at_out_stop, rsp_if.at_out_stop);
               compare_field("at_in_stop", want.at_in_stop, rsp_if.at_in_stop);
               compare_field("position_error", want.position_error, rsp_if.position_error);
               results_checked++;
               if (want.mode == MODE_CODE_REGULATE) regulate_seen++;
               if (want.at_in_stop) in_stop_seen++;
            end
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
   end

   // Watchdog: end the run when no handshake happens for too long
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(negedge clock);
      $display("%0t tb: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // Stimulus: directed items, randomized phases, a steady encoder walk, a tail without gaps
   initial begin
      req_if.valid      = 1'b0;
      req_if.func       = FUNC_LOOP;
      req_if.sensor_a   = 1'b0;
      req_if.sensor_b   = 1'b0;
      req_if.target_raw = 16'd0;
      rsp_if.ready      = 1'b0;

      ctl_cfg.speed_limit       = SPEED_LIMIT_RST;
      ctl_cfg.reset_speed       = RESET_SPEED_RST;
      ctl_cfg.ramp_step         = RAMP_STEP_RST;
      ctl_cfg.deadband          = DEADBAND_RST;
      ctl_cfg.torque_hold_ticks = TORQUE_HOLD_RST;
      ctl_cfg.drive_enable      = 1'b1;
      ctl_cfg.watchdog_seconds  = WATCHDOG_SEC_RST;
      ctl_cfg.reset_seconds     = RESET_SEC_RST;
      ctl_mode     = MODE_CODE_RESET_OUT;
      ctl_count    = 16'd0;
      ctl_target   = 16'd0;
      ctl_error    = 16'd0;
      ctl_sensor   = 2'd0;
      ctl_duty     = DUTY_MID;
      ctl_torque   = 1'b0;
      ctl_tick     = 1'b0;
      ctl_out_stop = 1'b0;
      ctl_in_stop  = 1'b0;
      ctl_hold     = 8'd0;
      ctl_wdog     = WATCHDOG_SEC_RST;
      ctl_secs     = RESET_SEC_RST;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      src_gaps_on = 1'b1;
      snk_gaps_on = 1'b1;

      // Reset-out drive, unused codes, target wrap, emergency and reset command
      push_event(FUNC_LOOP, 2'b01, 16'h0000);
      push_event(FUNC_LOOP, 2'b11, 16'hFFFF);
      push_event(3'd6, 2'b10, 16'hFFFF);
      push_event(3'd7, 2'b01, 16'h0000);
      push_event(FUNC_MS_TICK, 2'b00, 16'h5555);
      push_event(FUNC_SET_TGT, 2'b11, 16'hFFFF);
      push_event(FUNC_SET_TGT, 2'b00, 16'h4001);
      push_event(FUNC_SEC_TICK, 2'b10, 16'hAAAA);
      push_event(FUNC_EMERGENCY, 2'b01, 16'h0000);
      push_event(FUNC_LOOP, 2'b00, 16'h0000);
      push_event(FUNC_RESET, 2'b11, 16'hFFFF);
      push_event(FUNC_LOOP, 2'b00, 16'h0000);
      wait_idle();

      // Extreme settings; speed writes above the maximum must be dropped
      apply_settings(200, 0, 255, 0, 0, 1, 0, 0);
      csr_write(CSR_SPEED_LIMIT, 8'd255);
      csr_write(CSR_RESET_SPEED, 8'd201);

      // Leave reset-out, count below zero, skipped steps, watchdog clears target
      push_event(FUNC_RESET, 2'b10, 16'h0000);
      push_event(FUNC_LOOP, 2'b00, 16'hFFFF);
      push_event(FUNC_LOOP, 2'b01, 16'h0000);
      push_event(FUNC_MS_TICK, 2'b11, 16'h0000);
      push_event(FUNC_LOOP, 2'b01, 16'h0000);
      push_event(FUNC_LOOP, 2'b10, 16'h0000);
      push_event(FUNC_SEC_TICK, 2'b00, 16'h0000);
      push_event(FUNC_SET_TGT, 2'b00, 16'h0100);
      push_event(FUNC_MS_TICK, 2'b00, 16'h0000);
      push_event(FUNC_LOOP, 2'b11, 16'h0000);
      push_event(FUNC_SEC_TICK, 2'b00, 16'h0000);
      push_event(3'd7, 2'b11, 16'hFFFF);
      wait_idle();
      gen_ab = 2'b11;

      // Randomized phases, each under its own register settings
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: apply_settings(150, 200, 2, 0, 10, 1, 60, 1);
            1: apply_settings(200, 0, 255, 255, 0, 1, 0, 0);
            2: apply_settings(0, 200, 0, 3, 255, 1, 255, 2);
            3: apply_settings($urandom_range(0, 200), $urandom_range(0, 200),
                              $urandom_range(0, 255), $urandom_range(0, 40),
                              $urandom_range(0, 255), 1, $urandom_range(0, 10),
                              $urandom_range(0, 3));
            4: apply_settings(120, 150, 5, 8, 4, 0, 3, 0);
            default: apply_settings(50, 60, 1, 1, 2, 1, 2, 255);
         endcase
         src_gaps_on = ($urandom_range(0, 3) != 0);
         snk_gaps_on = ($urandom_range(0, 3) != 0);
         push_rehome();
         while (event_backlog.size() < PHASE_ITEMS) push_random_sequence();
         wait_idle();
      end

      // Walk steadily inward with periodic ms ticks toward a set target
      apply_settings(100, 100, 7, 5, 3, 1, 200, 0);
      src_gaps_on = 1'b1;
      snk_gaps_on = 1'b1;
      push_rehome();
      push_event(FUNC_SET_TGT, 2'($urandom), 16'd2000);
      for (int i = 0; i < WALK_STEPS; i++) begin
         gen_ab = quad_next(gen_ab, 1'b1);
         push_event(FUNC_LOOP, gen_ab, 16'($urandom));
         if (i % 8 == 0) push_event(FUNC_MS_TICK, 2'($urandom), 16'($urandom));
      end
      wait_idle();

      // Tail without idling on either side
      apply_settings($urandom_range(0, 200), $urandom_range(0, 200), $urandom_range(1, 20),
                     $urandom_range(0, 10), $urandom_range(0, 20), 1,
                     $urandom_range(0, 20), $urandom_range(0, 3));
      src_gaps_on = 1'b0;
      snk_gaps_on = 1'b0;
      push_rehome();
      while (event_backlog.size() < PHASE_ITEMS) push_random_sequence();
      wait_idle();
      repeat (8) @(posedge clock);

      if (expected_status_q.size() != 0) begin
         fail_count++;
         $display("%0t tb: %0d status items never arrived", $time, expected_status_q.size());
      end
      $display("tb: %0d items sent, %0d status items checked, %0d register writes",
               items_taken, results_checked, csr_writes);
      $display("tb: %0d in regulation, %0d at the inner stop, %0d mismatches",
               regulate_seen, in_stop_seen, fail_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/ppc_pkg.sv
hdl/ppc_channels.sv
hdl/ppc_csr.sv
hdl/ppc_engine.sv
hdl/piston_position_controller_unit.sv
tb/sv/tb.sv
